@@ sv/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types, constants and helpers for the LED matrix row scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int MATRIX_SIZE = 7;
    localparam int ROW_W       = MATRIX_SIZE;
    localparam int IDX_W       = $clog2(MATRIX_SIZE);
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    typedef logic [ROW_W-1:0]            row_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef row_t [MATRIX_SIZE-1:0]      frame_t;
    typedef logic [PADDR_W-1:0]          paddr_t;
    typedef logic [PDATA_W-1:0]          pdata_t;

    localparam idx_t LAST_ROW = idx_t'(MATRIX_SIZE - 1);

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    localparam paddr_t ADDR_ROTATION = paddr_t'(0);

    function automatic row_t reverse_row(input row_t v);
        row_t r;
        r = '0;
        for (int k = 0; k < MATRIX_SIZE; k++)
        begin
            r[MATRIX_SIZE-1-k] = v[k];
        end
        return r;
    endfunction

    function automatic row_t row_onehot(input idx_t r);
        row_t g;
        g = '0;
        for (int k = 0; k < MATRIX_SIZE; k++)
        begin
            g[k] = (r == idx_t'(k));
        end
        return g;
    endfunction

endpackage

@@ sv/lmrs_item_if.sv @@
// ----------------------------------------------------------------------------
// lmrs_item_if
// Input channel: frame row writes and scan ticks.
// ----------------------------------------------------------------------------
interface lmrs_item_if;

    logic              valid;
    logic              ready;
    logic              op;
    lmrs_pkg::idx_t    row_index;
    lmrs_pkg::row_t    row_bits;

    modport source
    (
        output valid,
        input  ready,
        output op,
        output row_index,
        output row_bits
    );

    modport sink
    (
        input  valid,
        output ready,
        input  op,
        input  row_index,
        input  row_bits
    );

endinterface

@@ sv/lmrs_result_if.sv @@
// ----------------------------------------------------------------------------
// lmrs_result_if
// Output channel: row gate and column drives for one scanned row.
// ----------------------------------------------------------------------------
interface lmrs_result_if;

    logic              valid;
    logic              ready;
    lmrs_pkg::row_t    row_gates;
    lmrs_pkg::row_t    column_drives;

    modport source
    (
        output valid,
        input  ready,
        output row_gates,
        output column_drives
    );

    modport sink
    (
        input  valid,
        output ready,
        input  row_gates,
        input  column_drives
    );

endinterface

@@ sv/lmrs_rotate.sv @@
// ----------------------------------------------------------------------------
// lmrs_rotate
// Picks one row of the rotated frame and maps it onto the column pins.
// ----------------------------------------------------------------------------
module lmrs_rotate
(
    input  lmrs_pkg::frame_t frame,
    input  lmrs_pkg::idx_t   row,
    input  lmrs_pkg::rot_t   rotation,
    output lmrs_pkg::row_t   column_drives
);

    lmrs_pkg::idx_t flip_row;
    lmrs_pkg::row_t rot_row;

    assign flip_row = lmrs_pkg::idx_t'(lmrs_pkg::LAST_ROW - row);

    always_comb
    begin
        rot_row = '0;
        case (rotation)
            lmrs_pkg::ROT_0:
            begin
                for (int k = 0; k < lmrs_pkg::MATRIX_SIZE; k++)
                begin
                    if (row == lmrs_pkg::idx_t'(k))
                    begin
                        rot_row = rot_row | frame[k];
                    end
                end
            end
            lmrs_pkg::ROT_90:
            begin
                // column j takes bit r of the mirrored row
                for (int j = 0; j < lmrs_pkg::MATRIX_SIZE; j++)
                begin
                    rot_row[j] = frame[lmrs_pkg::MATRIX_SIZE-1-j][row];
                end
            end
            lmrs_pkg::ROT_180:
            begin
                for (int k = 0; k < lmrs_pkg::MATRIX_SIZE; k++)
                begin
                    if (flip_row == lmrs_pkg::idx_t'(k))
                    begin
                        rot_row = rot_row | lmrs_pkg::reverse_row(frame[k]);
                    end
                end
            end
            default:
            begin
                for (int x = 0; x < lmrs_pkg::MATRIX_SIZE; x++)
                begin
                    rot_row[x] = frame[x][flip_row];
                end
            end
        endcase
    end

    // column pins take the rotated row in reversed order
    assign column_drives = lmrs_pkg::reverse_row(rot_row);

endmodule

@@ sv/led_matrix_rotating_row_scanner.sv @@
// ----------------------------------------------------------------------------
// led_matrix_rotating_row_scanner
// Row-multiplexed driver for a 7x7 LED matrix with 0/90/180/270 rotation.
// ----------------------------------------------------------------------------
// Holds a 7x7 frame, cleared at reset, that write transactions (op 0) fill one
// row at a time; a row index of 7 is ignored. Each tick transaction (op 1)
// advances the scan row (0 to 6, wrapping; the first tick after reset shows
// row 0) and returns one result: a one-hot row gate and the seven column
// drives for that row of the rotated frame. Writes return nothing. One
// transaction is accepted per cycle; a tick's result appears in the output
// register on the following cycle, and the block keeps accepting while that
// register is free or is being emptied in the same cycle. The rotation
// register sits at APB address 0 and should be written only while idle.
module led_matrix_rotating_row_scanner
(
    input  logic                    clk,
    input  logic                    rst_n,
    lmrs_item_if.sink               item,
    lmrs_result_if.source           result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  lmrs_pkg::paddr_t        paddr,
    input  lmrs_pkg::pdata_t        pwdata,
    output lmrs_pkg::pdata_t        prdata,
    output logic                    pready
);

    lmrs_pkg::frame_t frame_reg;
    lmrs_pkg::idx_t   scan_row_reg;
    lmrs_pkg::idx_t   scan_row_next;
    lmrs_pkg::rot_t   rotation_reg;
    logic             out_valid_reg;
    lmrs_pkg::row_t   gates_reg;
    lmrs_pkg::row_t   drives_reg;
    lmrs_pkg::row_t   drives_next;

    logic item_xact;
    logic tick_xact;
    logic write_xact;
    logic cfg_write;

    assign item.ready = !out_valid_reg || result.ready;
    assign item_xact  = item.valid && item.ready;
    assign tick_xact  = item_xact && (item.op == lmrs_pkg::OP_TICK);
    assign write_xact = item_xact && (item.op == lmrs_pkg::OP_WRITE);

    assign scan_row_next = (scan_row_reg == lmrs_pkg::LAST_ROW) ? '0
                         : lmrs_pkg::idx_t'(scan_row_reg + 1'b1);

    lmrs_rotate u_rotate
    (
        .frame         (frame_reg),
        .row           (scan_row_next),
        .rotation      (rotation_reg),
        .column_drives (drives_next)
    );

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == lmrs_pkg::ADDR_ROTATION);
    assign prdata    = (paddr == lmrs_pkg::ADDR_ROTATION)
                     ? lmrs_pkg::pdata_t'(rotation_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= lmrs_pkg::ROT_0;
        end
        else if (cfg_write)
        begin
            rotation_reg <= lmrs_pkg::rot_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg    <= '0;
            scan_row_reg <= lmrs_pkg::LAST_ROW;
        end
        else
        begin
            if (write_xact)
            begin
                for (int k = 0; k < lmrs_pkg::MATRIX_SIZE; k++)
                begin
                    if (item.row_index == lmrs_pkg::idx_t'(k))
                    begin
                        frame_reg[k] <= item.row_bits;
                    end
                end
            end
            if (tick_xact)
            begin
                scan_row_reg <= scan_row_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_xact)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xact)
        begin
            gates_reg  <= lmrs_pkg::row_onehot(scan_row_next);
            drives_reg <= drives_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.row_gates     = gates_reg;
    assign result.column_drives = drives_reg;

endmodule
